// ----- design/kolq_pkg.sv -----
// Package for the keyed ordered list queue: request codes, cell operations,
// field widths and the command struct that the top level sends to every cell.
// No dependencies.
package kolq_pkg;

  localparam int KEY_W        = 64;
  localparam int PAYLOAD_IO_W = 32;
  localparam int REQ_W        = 2;

  localparam logic [REQ_W-1:0] REQ_APPEND  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PREPEND = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SORTED  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_REMOVE  = 2'd3;

  // Per-cell update choice
  localparam logic [1:0] OP_HOLD       = 2'd0;
  localparam logic [1:0] OP_LOAD_NEW   = 2'd1;
  localparam logic [1:0] OP_FROM_LEFT  = 2'd2;
  localparam logic [1:0] OP_FROM_RIGHT = 2'd3;

  typedef logic signed [KEY_W-1:0] key_t;

  typedef struct packed {
    logic             active;  // request is carried out this cycle
    logic [REQ_W-1:0] req;
    key_t             key;     // key of the new entry (0 for append and prepend)
  } cell_cmd_t;

endpackage

// ----- design/kolq_if.sv -----
// Channel interfaces of the keyed ordered list queue: request and result.
// Depends on kolq_pkg.
interface kolq_req_if;
  logic                                valid;
  logic                                ready;
  logic [kolq_pkg::REQ_W-1:0]          req_type;
  logic [kolq_pkg::PAYLOAD_IO_W-1:0]   payload;
  logic signed [kolq_pkg::KEY_W-1:0]   sort_key;

  modport source (output valid, output req_type, output payload, output sort_key,
                  input ready);
  modport sink   (input valid, input req_type, input payload, input sort_key,
                  output ready);
endinterface

interface kolq_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [kolq_pkg::PAYLOAD_IO_W-1:0]   removed_payload;
  logic signed [kolq_pkg::KEY_W-1:0]   removed_key;
  logic                                removed_valid;
  logic                                insert_dropped;
  logic                                now_empty;

  modport source (output valid, output removed_payload, output removed_key,
                  output removed_valid, output insert_dropped, output now_empty,
                  input ready);
  modport sink   (input valid, input removed_payload, input removed_key,
                  input removed_valid, input insert_dropped, input now_empty,
                  output ready);
endinterface

// ----- design/kolq_cell.sv -----
// One slot of the ordered list: holds a key and an item, compares against the
// incoming key and shifts toward the head or the tail. Depends on kolq_pkg.
module kolq_cell #(
  parameter int IDX   = 0,
  parameter int OCC_W = 5,
  parameter int PW    = 32
) (
  input  logic                      clk,
  input  kolq_pkg::cell_cmd_t       cmd,
  input  logic [OCC_W-1:0]          occ,
  input  logic [PW-1:0]             new_pay,
  input  kolq_pkg::key_t            left_key,
  input  logic [PW-1:0]             left_pay,
  input  kolq_pkg::key_t            right_key,
  input  logic [PW-1:0]             right_pay,
  input  logic                      found_in,
  output logic                      found_out,
  output kolq_pkg::key_t            key_q,
  output logic [PW-1:0]             pay_q
);

  kolq_pkg::key_t  key_r;
  logic [PW-1:0]   pay_r;
  logic            occupied;
  logic            greater;
  logic            at_tail;
  logic [1:0]      op;

  assign occupied  = OCC_W'(IDX) < occ;
  assign greater   = occupied && (key_r > cmd.key);
  assign found_out = found_in || greater;
  assign at_tail   = OCC_W'(IDX) == occ;

  always_comb begin
    op = kolq_pkg::OP_HOLD;
    if (cmd.active) begin
      case (cmd.req)
        kolq_pkg::REQ_APPEND: begin
          if (at_tail) op = kolq_pkg::OP_LOAD_NEW;
        end
        kolq_pkg::REQ_PREPEND: begin
          op = (IDX == 0) ? kolq_pkg::OP_LOAD_NEW : kolq_pkg::OP_FROM_LEFT;
        end
        kolq_pkg::REQ_SORTED: begin
          // first greater entry (or the free tail slot) takes the new one, everything behind it moves back
          if (found_in)                 op = kolq_pkg::OP_FROM_LEFT;
          else if (greater || at_tail)  op = kolq_pkg::OP_LOAD_NEW;
        end
        kolq_pkg::REQ_REMOVE: begin
          op = kolq_pkg::OP_FROM_RIGHT;
        end
        default: op = kolq_pkg::OP_HOLD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      kolq_pkg::OP_LOAD_NEW: begin
        key_r <= cmd.key;
        pay_r <= new_pay;
      end
      kolq_pkg::OP_FROM_LEFT: begin
        key_r <= left_key;
        pay_r <= left_pay;
      end
      kolq_pkg::OP_FROM_RIGHT: begin
        key_r <= right_key;
        pay_r <= right_pay;
      end
      default: begin
        key_r <= key_r;
        pay_r <= pay_r;
      end
    endcase
  end

  assign key_q = key_r;
  assign pay_q = pay_r;

endmodule

// ----- design/keyed_ordered_list_queue_core.sv -----
// Top level of the keyed ordered list queue: a row of list cells, the
// occupancy counter and the result register. Depends on kolq_pkg, kolq_if
// and kolq_cell.
//
// A bounded list of up to CAPACITY (key, item) entries, head first. Each
// request (append, prepend, sorted insert, remove head) gives one result; a
// new request is accepted in every cycle in which the result register is
// empty or its contents are being taken. The result appears in the cycle
// after the request transfer, when all cells update together; the clock rate
// is set by the key compare in each cell followed by the found signal
// rippling from head to tail across the whole row.
// Inserts into a full list are dropped and flagged; entries never written
// are never read, so the cells need no clearing after reset.
module keyed_ordered_list_queue_core #(
  parameter int CAPACITY      = 16,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  kolq_req_if.sink        in_ch,
  kolq_rsp_if.source      out_ch
);

  localparam int OCC_W = $clog2(CAPACITY + 1);
  localparam int PW    = PAYLOAD_WIDTH;

  logic [OCC_W-1:0]     occ_r, occ_nxt;
  logic                 out_valid_r;
  logic [kolq_pkg::PAYLOAD_IO_W-1:0] out_pay_r;
  kolq_pkg::key_t       out_key_r;
  logic                 out_rv_r, out_drop_r, out_empty_r;

  logic                 xfer;
  logic                 is_remove;
  logic                 full, empty;
  logic                 dropped;
  kolq_pkg::cell_cmd_t  cmd;
  logic [63:0]          in_pay_wide;
  logic [PW-1:0]        new_pay;
  logic [63:0]          head_pay_wide;

  kolq_pkg::key_t       key_q  [CAPACITY];
  logic [PW-1:0]        pay_q  [CAPACITY];
  logic [CAPACITY:0]    found;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign xfer        = in_ch.valid && in_ch.ready;
  assign is_remove   = in_ch.req_type == kolq_pkg::REQ_REMOVE;
  assign full        = occ_r == OCC_W'(CAPACITY);
  assign empty       = occ_r == '0;
  assign dropped     = !is_remove && full;

  // keep only the low PAYLOAD_WIDTH bits of the item
  assign in_pay_wide = 64'(in_ch.payload);
  assign new_pay     = in_pay_wide[PW-1:0];

  assign cmd.active = xfer && !dropped && !(is_remove && empty);
  assign cmd.req    = in_ch.req_type;
  assign cmd.key    = (in_ch.req_type == kolq_pkg::REQ_SORTED) ? in_ch.sort_key : '0;

  assign found[0] = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    kolq_pkg::key_t lk, rk;
    logic [PW-1:0]  lp, rp;
    if (i == 0) begin : g_head
      assign lk = key_q[i];
      assign lp = pay_q[i];
    end else begin : g_mid_l
      assign lk = key_q[i-1];
      assign lp = pay_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign rk = key_q[i];
      assign rp = pay_q[i];
    end else begin : g_mid_r
      assign rk = key_q[i+1];
      assign rp = pay_q[i+1];
    end

    kolq_cell #(
      .IDX   (i),
      .OCC_W (OCC_W),
      .PW    (PW)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .occ       (occ_r),
      .new_pay   (new_pay),
      .left_key  (lk),
      .left_pay  (lp),
      .right_key (rk),
      .right_pay (rp),
      .found_in  (found[i]),
      .found_out (found[i+1]),
      .key_q     (key_q[i]),
      .pay_q     (pay_q[i])
    );
  end

  always_comb begin
    occ_nxt = occ_r;
    if (cmd.active) begin
      if (is_remove) occ_nxt = occ_r - OCC_W'(1);
      else           occ_nxt = occ_r + OCC_W'(1);
    end
  end

  assign head_pay_wide = 64'(pay_q[0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
      if (xfer)              out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // result fields: hold until taken, load on each request transfer
  always_ff @(posedge clk) begin
    if (xfer) begin
      if (is_remove && !empty) begin
        out_pay_r <= head_pay_wide[kolq_pkg::PAYLOAD_IO_W-1:0];
        out_key_r <= key_q[0];
        out_rv_r  <= 1'b1;
      end else begin
        out_pay_r <= '0;
        out_key_r <= '0;
        out_rv_r  <= 1'b0;
      end
      out_drop_r  <= dropped;
      out_empty_r <= occ_nxt == '0;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.removed_payload = out_pay_r;
  assign out_ch.removed_key     = out_key_r;
  assign out_ch.removed_valid   = out_rv_r;
  assign out_ch.insert_dropped  = out_drop_r;
  assign out_ch.now_empty       = out_empty_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(CAPACITY))
    else $error("occupancy above capacity");

  a_remove_hit: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && is_remove && !empty |=> out_valid_r && out_rv_r && !out_drop_r)
    else $error("remove of a stored entry did not report it");

  a_drop_holds: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && dropped |=> $stable(occ_r) && out_drop_r && !out_empty_r)
    else $error("dropped insert changed the list");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    xfer |=> out_empty_r == (occ_r == '0))
    else $error("empty flag disagrees with occupancy");

endmodule
